[sv/mddt_pkg.sv]
//------------------------------------------------------------------------------
// mddt_pkg
// Shared types and constants for the modular power difference test block.
//------------------------------------------------------------------------------
package mddt_pkg;

	localparam int ModulusWidthDefault  = 64;
	localparam int ExponentWidthDefault = 32;
	localparam int RegWidth             = 32;
	localparam int RegIndexWidth        = 2;

	localparam logic [RegWidth-1:0] FirstBaseReset      = 32'd2;
	localparam logic [RegWidth-1:0] FirstExponentReset  = 32'd272500658;
	localparam logic [RegWidth-1:0] SecondBaseReset     = 32'd3;
	localparam logic [RegWidth-1:0] SecondExponentReset = 32'd171928773;

	localparam logic [RegIndexWidth-1:0] RegFirstBase      = 2'd0;
	localparam logic [RegIndexWidth-1:0] RegFirstExponent  = 2'd1;
	localparam logic [RegIndexWidth-1:0] RegSecondBase     = 2'd2;
	localparam logic [RegIndexWidth-1:0] RegSecondExponent = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BASE_START,
		ST_BASE_WAIT,
		ST_MUL_START,
		ST_MUL_WAIT,
		ST_SQR_START,
		ST_SQR_WAIT,
		ST_NEXT,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture modulus, start with the first power
		logic base_start; // reduce base mod p (shift-add by one)
		logic mul_start;  // acc := acc * sq mod p
		logic sqr_start;  // sq := sq * sq mod p
		logic shift_exp;  // drop the low exponent bit
		logic next_power; // store first residue, set up second power
		logic finish;     // write result register
	} dp_cmd_t;

	typedef struct packed {
		logic mm_busy;
		logic exp_bit;
		logic exp_last;  // remaining exponent is at most one bit
		logic exp_zero;
		logic second;    // working on the second power
	} dp_status_t;

endpackage

[sv/mddt_modmul.sv]
//------------------------------------------------------------------------------
// mddt_modmul
// Bit-serial modular multiplier: x * y mod m, one multiplier bit per cycle.
//------------------------------------------------------------------------------
module mddt_modmul #(
	parameter int W  = mddt_pkg::ModulusWidthDefault,
	parameter int YW = W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  x,
	input  logic [YW-1:0] y,
	input  logic [W-1:0]  m,
	output logic          busy,
	output logic [W-1:0]  result
);
	import mddt_pkg::*;

	localparam int CW = $clog2(YW + 1);

	logic [W-1:0]  acc_q;
	logic [W-1:0]  x_q;
	logic [YW-1:0] y_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    dbl;
	logic [W-1:0]  dbl_r;
	logic [W:0]    add;
	logic [W-1:0]  add_r;

	// Both operands are below m, so one conditional subtract reduces each step.
	always_comb begin
		dbl   = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, m}) ? W'(dbl - {1'b0, m}) : dbl[W-1:0];
		add   = {1'b0, dbl_r} + {1'b0, x_q};
		add_r = (add >= {1'b0, m}) ? W'(add - {1'b0, m}) : add[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(YW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (busy_q) begin
			acc_q <= y_q[YW-1] ? add_r : dbl_r;
			y_q   <= {y_q[YW-2:0], 1'b0};
		end
	end

	assign busy   = busy_q;
	assign result = acc_q;

`ifndef ASSERT_OFF
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == '0) else $error("counter nonzero while idle");
	a_res_lt_m: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) && (x_q < m) && (m != '0) |-> acc_q < m)
		else $error("product not reduced");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("start did not raise busy");
`endif
endmodule

[sv/mddt_datapath.sv]
//------------------------------------------------------------------------------
// mddt_datapath
// Operand registers, exponent shifter and the shared modular multiplier.
//------------------------------------------------------------------------------
module mddt_datapath #(
	parameter int MW = mddt_pkg::ModulusWidthDefault,
	parameter int EW = mddt_pkg::ExponentWidthDefault
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mddt_pkg::dp_cmd_t                  cmd,
	input  logic [63:0]                        modulus,
	input  logic [mddt_pkg::RegWidth-1:0]      first_base,
	input  logic [mddt_pkg::RegWidth-1:0]      first_exponent,
	input  logic [mddt_pkg::RegWidth-1:0]      second_base,
	input  logic [mddt_pkg::RegWidth-1:0]      second_exponent,
	output mddt_pkg::dp_status_t               status,
	output logic [63:0]                        first_residue,
	output logic [63:0]                        second_residue,
	output logic                               divides
);
	import mddt_pkg::*;

	localparam int BW = (RegWidth > MW) ? RegWidth : MW;

	logic [MW-1:0] m_q;
	logic [MW-1:0] acc_q;
	logic [MW-1:0] sq_q;
	logic [MW-1:0] first_q;
	logic [EW-1:0] e_q;
	logic          second_q;
	logic [63:0]   res1_q;
	logic [63:0]   res2_q;
	logic          div_q;
	logic          mm_start;
	logic [MW-1:0] mm_x;
	logic [BW-1:0] mm_y;
	logic [MW-1:0] mm_res;
	logic          mm_busy;
	logic [MW-1:0] one_mod;
	logic [BW-1:0] base_ext;

	assign one_mod = (m_q == MW'(1)) ? '0 : MW'(1);

	// Exponents are used in their low EW bits.
	function automatic logic [EW-1:0] pick_exp(input logic [RegWidth-1:0] e);
		logic [63:0] w;
		begin
			w = 64'(e);
			return w[EW-1:0];
		end
	endfunction

	assign base_ext = second_q ? BW'(second_base) : BW'(first_base);

	// For base reduction x = 1 mod p and y = the full base; the shift-add
	// stays reduced although y itself may exceed m.
	always_comb begin
		mm_start = cmd.base_start | cmd.mul_start | cmd.sqr_start;
		if (cmd.base_start) begin
			mm_x = one_mod;
			mm_y = base_ext;
		end else if (cmd.mul_start) begin
			mm_x = acc_q;
			mm_y = BW'(sq_q);
		end else begin
			mm_x = sq_q;
			mm_y = BW'(sq_q);
		end
	end

	mddt_modmul #(.W(MW), .YW(BW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.x      (mm_x),
		.y      (mm_y),
		.m      (m_q),
		.busy   (mm_busy),
		.result (mm_res)
	);

	typedef enum logic [1:0] {W_NONE, W_BASE, W_ACC, W_SQ} wb_t;
	wb_t wb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q     <= W_NONE;
			second_q <= 1'b0;
			div_q    <= 1'b0;
		end else begin
			if (cmd.base_start) wb_q <= W_BASE;
			else if (cmd.mul_start) wb_q <= W_ACC;
			else if (cmd.sqr_start) wb_q <= W_SQ;
			else if (!mm_busy) wb_q <= W_NONE;
			if (cmd.load) second_q <= 1'b0;
			else if (cmd.next_power) second_q <= 1'b1;
			if (cmd.finish) div_q <= (m_q != '0) && (first_q == acc_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q <= modulus[MW-1:0];
		end
		if (cmd.load || cmd.next_power) begin
			acc_q <= (modulus[MW-1:0] == MW'(1) && cmd.load) ? '0 :
				(cmd.load ? MW'(1) : one_mod);
			e_q   <= cmd.load ? pick_exp(first_exponent) : pick_exp(second_exponent);
		end else if (cmd.shift_exp) begin
			e_q <= e_q >> 1;
		end else if (!mm_busy && wb_q == W_ACC) begin
			acc_q <= mm_res;
		end
		if (!mm_busy && (wb_q == W_BASE || wb_q == W_SQ)) begin
			sq_q <= mm_res;
		end
		if (cmd.next_power) begin
			first_q <= acc_q;
		end
		if (cmd.finish) begin
			res1_q <= (m_q == '0) ? '0 : 64'(first_q);
			res2_q <= (m_q == '0) ? '0 : 64'(acc_q);
		end
	end

	assign status.mm_busy  = mm_busy | (wb_q != W_NONE);
	assign status.exp_bit  = e_q[0];
	assign status.exp_last = (e_q >> 1) == '0;
	assign status.exp_zero = (e_q == '0);
	assign status.second   = second_q;
	assign first_residue   = res1_q;
	assign second_residue  = res2_q;
	assign divides         = div_q;

`ifndef ASSERT_OFF
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.base_start, cmd.mul_start, cmd.sqr_start}))
		else $error("two multiplier commands at once");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_start || cmd.sqr_start) |-> !mm_busy)
		else $error("multiplier started while busy");
	a_acc_red: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && m_q != '0 |-> acc_q < m_q) else $error("residue not reduced");
`endif
endmodule

[sv/mddt_ctrl.sv]
//------------------------------------------------------------------------------
// mddt_ctrl
// Sequencer for right-to-left square-and-multiply over two powers.
//------------------------------------------------------------------------------
module mddt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  mddt_pkg::dp_status_t status,
	output mddt_pkg::dp_cmd_t    cmd
);
	import mddt_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (s_tvalid && !out_valid_q) state_d = ST_BASE_START;
			ST_BASE_START: state_d = ST_BASE_WAIT;
			ST_BASE_WAIT:  if (!status.mm_busy) state_d = status.exp_zero ? ST_NEXT :
				(status.exp_bit ? ST_MUL_START : (status.exp_last ? ST_NEXT : ST_SQR_START));
			ST_MUL_START:  state_d = ST_MUL_WAIT;
			ST_MUL_WAIT:   if (!status.mm_busy) state_d = status.exp_last ? ST_NEXT : ST_SQR_START;
			ST_SQR_START:  state_d = ST_SQR_WAIT;
			ST_SQR_WAIT:   if (!status.mm_busy) state_d = status.exp_bit ? ST_MUL_START :
				(status.exp_last ? ST_NEXT : ST_SQR_START);
			ST_NEXT:       state_d = status.second ? ST_DONE : ST_BASE_START;
			ST_DONE:       state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// The exponent shifts as each squaring starts, so the bit seen after it is
	// the next one to multiply by.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:       cmd.load = s_tvalid && !out_valid_q;
			ST_BASE_START: cmd.base_start = 1'b1;
			ST_MUL_START:  cmd.mul_start = 1'b1;
			ST_SQR_START:  begin
				cmd.sqr_start = 1'b1;
				cmd.shift_exp = 1'b1;
			end
			ST_NEXT:       cmd.next_power = !status.second;
			ST_DONE:       cmd.finish = 1'b1;
			default:       cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign m_tvalid = out_valid_q;

`ifndef ASSERT_OFF
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_BASE_START)
		else $error("accept did not start work");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> m_tvalid) else $error("result not presented");
	a_busy_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_tready) else $error("ready while working");
`endif
endmodule

[sv/modexp_difference_divisibility_test_core.sv]
// Work: each modular multiplication runs on the bit-serial multiplier. A power costs
// one base reduction, one multiply per set exponent bit and one squaring per bit below
// the top set bit.
// Throughput: one item at a time; next item accepted the cycle after the result is taken.
// Reset: arst_n clears control and restores the configuration registers to their reset values.
//------------------------------------------------------------------------------
// modexp_difference_divisibility_test_core
// Computes two modular powers modulo a given modulus and flags equal residues.
//------------------------------------------------------------------------------
module modexp_difference_divisibility_test_core #(
	parameter int MODULUS_WIDTH  = mddt_pkg::ModulusWidthDefault,
	parameter int EXPONENT_WIDTH = mddt_pkg::ExponentWidthDefault
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [63:0]                          s_tdata,  // [63:0] modulus
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [135:0]                         m_tdata,  // first_residue, second_residue, divides, zero pad
	input  logic                                 cfg_we,
	input  logic [mddt_pkg::RegIndexWidth-1:0]   cfg_index,
	input  logic [mddt_pkg::RegWidth-1:0]        cfg_data
);
	import mddt_pkg::*;

	logic [RegWidth-1:0] fb_q, fe_q, sb_q, se_q;
	dp_cmd_t    cmd;
	dp_status_t status;
	logic [63:0] r1, r2;
	logic        dv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_q <= FirstBaseReset;
			fe_q <= FirstExponentReset;
			sb_q <= SecondBaseReset;
			se_q <= SecondExponentReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegFirstBase:      fb_q <= cfg_data;
				RegFirstExponent:  fe_q <= cfg_data;
				RegSecondBase:     sb_q <= cfg_data;
				RegSecondExponent: se_q <= cfg_data;
				default:           fb_q <= fb_q;
			endcase
		end
	end

	mddt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	mddt_datapath #(.MW(MODULUS_WIDTH), .EW(EXPONENT_WIDTH)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.modulus         (s_tdata),
		.first_base      (fb_q),
		.first_exponent  (fe_q),
		.second_base     (sb_q),
		.second_exponent (se_q),
		.status          (status),
		.first_residue   (r1),
		.second_residue  (r2),
		.divides         (dv)
	);

	assign m_tdata = {7'd0, dv, r2, r1};
endmodule
